// File: rtl/assert_macros.svh
// Assertion macros used by the checker module of this block.
// Each macro expects the clock i_clk and the active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define WPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included, for reset behavior.
`define WPR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/wpr_pkg.sv
package wpr_pkg;

    // Item kinds carried on the op field.
    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // 60000 ms per minute, times 256 for the eight fractional bits.
    localparam int unsigned RATE_SCALE = 32'd15360000;

    // Reset value of the eviction age limit.
    localparam logic [31:0] MAX_GAP_RESET = 32'd60000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EV_RD,
        ST_EV_CHK,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

// File: rtl/windowed_pulse_rate_meter_core.sv
// Windowed pulse rate meter. Each input word is a pulse (op = 0) or an evaluation tick
// (op = 1), stamped with the current time in milliseconds. Pulse stamps live in a
// FIFO_DEPTH-entry memory used as a ring; when it is full the oldest stamp is dropped.
// A tick drops, from the oldest end, every stamp whose age exceeds max_gap_ms, then
// returns one output word: the number of stamps left and the rate in counts per
// minute with eight fractional bits, floor(15360000 * (n - 1) / (newest - oldest)).
// Fewer than two stamps give a rate of zero; a zero span or a quotient above 32 bits
// gives all ones with o_saturated set. Ages and spans wrap modulo 2^TIME_BITS.
// Timing: a pulse is stored while the block stays idle and produces no output word.
// A tick runs the eviction walk, a read state and a check state for each stamp it
// examines, ending on a read state alone when every stamp is evicted (the read port
// of the stamp memory is registered, so the oldest stamp is checked in the state after
// its read), then the numerator multiply, the radix-2 divider at one quotient bit per
// cycle (33 bits at the default depth, skipped when fewer than two stamps remain or
// the span is zero), and the load of the output register. At the default depth a
// tick keeps the input side closed longest, when the output register is free, with
// 62 evictions leaving two stamps, then the multiply, the divide and the load. The
// input side accepts a new word only when the block is idle, but a finished result
// may still wait in the output register while the next word is taken. max_gap_ms is
// written through i_cfg_we / i_cfg_wdata and resets to 60000.
module windowed_pulse_rate_meter_core #(
    parameter int FIFO_DEPTH = 64,
    parameter int TIME_BITS  = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_op,
    input  logic [TIME_BITS-1:0] i_now_ms,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_rate_q8,
    output logic [6:0]           o_pulses_in_window,
    output logic                 o_saturated
);
    import wpr_pkg::*;

    // Index into the ring, and a count that can hold the full depth.
    localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // The numerator is at most RATE_SCALE * (FIFO_DEPTH - 1). The quotient register
    // keeps at least 33 bits so that a result above 32 bits can be seen.
    localparam longint unsigned NUM_MAX = longint'(RATE_SCALE) * longint'(FIFO_DEPTH - 1);
    localparam int NUM_W = $clog2(NUM_MAX + 1);
    localparam int QW    = (NUM_W > 32) ? NUM_W : 33;
    localparam int DC_W  = $clog2(QW);

    // Stamp memory: one write port, one registered read port.
    logic [TIME_BITS-1:0] mem [FIFO_DEPTH];
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [TIME_BITS-1:0] r_rd_data;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_head, n_head;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic [TIME_BITS-1:0] r_newest, n_newest;
    logic [31:0]          r_max_gap;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [TIME_BITS-1:0] r_span, n_span;
    logic [QW-1:0]        r_quo, n_quo;
    logic [TIME_BITS-1:0] r_rem, n_rem;
    logic [DC_W-1:0]      r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [31:0]          r_rate, n_rate;
    logic [6:0]           r_count, n_count;
    logic                 r_sat, n_sat;

    logic                 in_accept;
    logic                 out_load;
    logic [IDX_W-1:0]     head_inc;
    logic [SUM_W-1:0]     tail_sum;
    logic [IDX_W-1:0]     tail_idx;
    logic [TIME_BITS-1:0] age;
    logic [TIME_BITS:0]   rem_sh;
    logic [TIME_BITS:0]   rem_diff;
    logic                 fill_short;
    logic                 quo_over;

    // The newest stamp is always the tail entry, so it is kept in a register and
    // the memory needs only the one read port for the oldest stamp.
    always_comb begin
        head_inc = (r_head == IDX_W'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
        tail_sum = SUM_W'(r_head) + SUM_W'(r_fill);
        if (tail_sum >= SUM_W'(FIFO_DEPTH)) begin
            tail_idx = IDX_W'(tail_sum - SUM_W'(FIFO_DEPTH));
        end else begin
            tail_idx = IDX_W'(tail_sum);
        end
        age        = r_now - r_rd_data;
        rem_sh     = {r_rem, r_quo[QW-1]};
        rem_diff   = rem_sh - {1'b0, r_span};
        fill_short = (r_fill < CNT_W'(2));
        quo_over   = |r_quo[QW-1:32];
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_newest    = r_newest;
        n_now       = r_now;
        n_span      = r_span;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_rate      = r_rate;
        n_count     = r_count;
        n_sat       = r_sat;
        o_in_ready  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = tail_idx;
        out_load    = 1'b0;
        in_accept   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                in_accept  = i_in_valid;
                if (i_in_valid) begin
                    if (i_op == OP_PULSE) begin
                        mem_we   = 1'b1;
                        n_newest = i_now_ms;
                        if (r_fill == CNT_W'(FIFO_DEPTH)) begin
                            // Full ring: the new stamp overwrites the oldest one.
                            mem_waddr = r_head;
                            n_head    = head_inc;
                        end else begin
                            n_fill = r_fill + 1'b1;
                        end
                    end else begin
                        n_now   = i_now_ms;
                        n_state = ST_EV_RD;
                    end
                end
            end
            ST_EV_RD: begin
                // The memory reads the head entry in this cycle.
                n_state = (r_fill == '0) ? ST_MUL : ST_EV_CHK;
            end
            ST_EV_CHK: begin
                if (age > TIME_BITS'(r_max_gap)) begin
                    n_head  = head_inc;
                    n_fill  = r_fill - 1'b1;
                    n_state = ST_EV_RD;
                end else begin
                    n_span  = r_newest - r_rd_data;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_quo = QW'(RATE_SCALE) * QW'(r_fill - 1'b1);
                n_rem = '0;
                n_cnt = DC_W'(QW - 1);
                if (fill_short || r_span == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle; the numerator
                // shifts out of r_quo as the quotient shifts in.
                if (!rem_diff[TIME_BITS]) begin
                    n_rem = rem_diff[TIME_BITS-1:0];
                    n_quo = {r_quo[QW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[TIME_BITS-1:0];
                    n_quo = {r_quo[QW-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_count  = 7'(r_fill);
                    if (fill_short) begin
                        n_rate = '0;
                        n_sat  = 1'b0;
                    end else if (r_span == '0 || quo_over) begin
                        n_rate = '1;
                        n_sat  = 1'b1;
                    end else begin
                        n_rate = r_quo[31:0];
                        n_sat  = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_newest    <= '0;
            r_max_gap   <= MAX_GAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_newest    <= n_newest;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max_gap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now   <= n_now;
        r_span  <= n_span;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_rate  <= n_rate;
        r_count <= n_count;
        r_sat   <= n_sat;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && in_accept) begin
            mem[mem_waddr] <= i_now_ms;
        end
        r_rd_data <= mem[r_head];
    end

    assign o_out_valid        = r_out_valid;
    assign o_rate_q8          = r_rate;
    assign o_pulses_in_window = r_count;
    assign o_saturated        = r_sat;

endmodule

// File: rtl/wpr_checker.sv
`include "assert_macros.svh"

module wpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_op,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_rate_q8,
    input logic        o_saturated
);
    import wpr_pkg::*;

    logic in_take;
    logic out_wait;

    assign in_take  = i_in_valid && o_in_ready;
    assign out_wait = o_out_valid && !i_out_ready;

    // Reset leaves the block empty and ready for a word.
    `WPR_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_out_valid && o_in_ready), "reset state wrong")

    // A tick starts the eviction walk, so the input side closes once the tick is taken.
    `WPR_ASSERT(a_tick_busy, (in_take && i_op == OP_TICK) |=> !o_in_ready, "ready after tick")

    // A pulse is stored without leaving the idle state, so the block stays open.
    `WPR_ASSERT(a_pulse_fast, (in_take && i_op == OP_PULSE) |=> o_in_ready, "busy after pulse")

    // A clipped rate is always all ones.
    `WPR_ASSERT(a_sat_ones, (o_out_valid && o_saturated) |-> (o_rate_q8 == '1), "clipped rate")

    // A result that is not taken holds.
    `WPR_ASSERT(a_out_hold, out_wait |=> (o_out_valid && $stable(o_rate_q8)), "result dropped")

endmodule

bind windowed_pulse_rate_meter_core wpr_checker u_wpr_checker (.*);
